/* src/tick_task_dispatch_table_core_macros.svh */
// assertion macros for the tick task dispatch table
`ifndef TICK_TASK_DISPATCH_TABLE_CORE_MACROS_SVH
`define TICK_TASK_DISPATCH_TABLE_CORE_MACROS_SVH

// expression holds at every clock edge out of reset
`define TTD_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ttd assertion failed");

// consequent holds in the cycle after the antecedent
`define TTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttd assertion failed");

// consequent holds in the same cycle as the antecedent
`define TTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttd assertion failed");

`endif

/* src/ttd_pkg.sv */
// shared constants, codes and types of the tick task dispatch table
package ttd_pkg;

  localparam int SLOT_COUNT     = 8;
  localparam int MIN_RESOLUTION = 1;
  localparam int MAX_RESULTS    = 8;

  localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UCNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int NCNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int HANDLE_W = 8;
  localparam int RES_W    = 8;

  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_IDLE     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_INIT  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_TAKEN     = 3'd3,
    STAT_BAD_MODE  = 3'd4,
    STAT_ONE_SHOT  = 3'd5,
    STAT_NOT_FOUND = 3'd6,
    STAT_NULL      = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_STOP,
    ST_TICK_INC,
    ST_TICK_SCAN,
    ST_TICK_HIT,
    ST_TICK_DONE
  } state_e;

  typedef enum logic [1:0] {
    TW_NONE,
    TW_CREATE,
    TW_FREE,
    TW_RELOAD
  } tw_op_e;

  typedef struct packed {
    tw_op_e                op;
    logic [SLOT_W-1:0]     idx;
    logic [TICK_W-1:0]     deadline;
    logic [PERIOD_W-1:0]   period;
    logic [HANDLE_W-1:0]   handle;
    logic                  periodic;
  } tbl_wr_t;

  typedef struct packed {
    logic                  busy;
    logic                  periodic;
    logic [TICK_W-1:0]     deadline;
    logic [PERIOD_W-1:0]   period;
    logic [HANDLE_W-1:0]   handle;
  } tbl_rd_t;

  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic [2:0]            fired_slot;
    logic [HANDLE_W-1:0]   fired_handle;
    logic                  last;
  } result_t;

endpackage

/* src/ttd_alu.sv */
// shared 32-bit adder and equality compare
module ttd_alu (
  input  logic [ttd_pkg::TICK_W-1:0] a_i,
  input  logic [ttd_pkg::TICK_W-1:0] b_i,
  output logic [ttd_pkg::TICK_W-1:0] sum_o,
  output logic                       eq_o
);

  assign sum_o = a_i + b_i;
  assign eq_o  = (a_i == b_i);

endmodule

/* src/ttd_slot_table.sv */
// task slot storage with busy and periodic flags
module ttd_slot_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ttd_pkg::tbl_wr_t                wr_i,
  input  logic [ttd_pkg::SLOT_W-1:0]      rd_idx_i,
  output ttd_pkg::tbl_rd_t                rd_o,
  output logic [ttd_pkg::SLOT_COUNT-1:0]  busy_o
);

  logic [ttd_pkg::SLOT_COUNT-1:0] busy_q;
  logic [ttd_pkg::SLOT_COUNT-1:0] periodic_q;
  logic [ttd_pkg::TICK_W-1:0]     deadline_q [ttd_pkg::SLOT_COUNT];
  logic [ttd_pkg::PERIOD_W-1:0]   period_q   [ttd_pkg::SLOT_COUNT];
  logic [ttd_pkg::HANDLE_W-1:0]   handle_q   [ttd_pkg::SLOT_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      periodic_q <= '0;
    end else begin
      unique case (wr_i.op)
        ttd_pkg::TW_CREATE: begin
          busy_q[wr_i.idx]     <= 1'b1;
          periodic_q[wr_i.idx] <= wr_i.periodic;
        end
        ttd_pkg::TW_FREE: begin
          busy_q[wr_i.idx]     <= 1'b0;
          periodic_q[wr_i.idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (wr_i.op)
      ttd_pkg::TW_CREATE: begin
        deadline_q[wr_i.idx] <= wr_i.deadline;
        period_q[wr_i.idx]   <= wr_i.period;
        handle_q[wr_i.idx]   <= wr_i.handle;
      end
      ttd_pkg::TW_RELOAD: begin
        deadline_q[wr_i.idx] <= wr_i.deadline;
      end
      default: begin
      end
    endcase
  end

  assign rd_o.busy     = busy_q[rd_idx_i];
  assign rd_o.periodic = periodic_q[rd_idx_i];
  assign rd_o.deadline = deadline_q[rd_idx_i];
  assign rd_o.period   = period_q[rd_idx_i];
  assign rd_o.handle   = handle_q[rd_idx_i];
  assign busy_o        = busy_q;

endmodule

/* src/ttd_ctrl.sv */
// sequencer: request decode, slot scan, tick counter and result register
module ttd_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttd_pkg::RES_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ttd_pkg::action_e                in_action_i,
  input  logic [2:0]                      in_slot_i,
  input  logic [ttd_pkg::PERIOD_W-1:0]    in_period_i,
  input  logic [1:0]                      in_mode_i,
  input  logic [ttd_pkg::HANDLE_W-1:0]    in_handle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ttd_pkg::result_t                out_o,
  output logic [ttd_pkg::SLOT_W-1:0]      tbl_rd_idx_o,
  input  ttd_pkg::tbl_rd_t                tbl_rd_i,
  output ttd_pkg::tbl_wr_t                tbl_wr_o,
  output logic [ttd_pkg::TICK_W-1:0]      alu_a_o,
  output logic [ttd_pkg::TICK_W-1:0]      alu_b_o,
  input  logic [ttd_pkg::TICK_W-1:0]      alu_sum_i,
  input  logic                            alu_eq_i,
  output logic [ttd_pkg::UCNT_W-1:0]      used_o
);

  localparam logic [ttd_pkg::SLOT_W-1:0] LAST_IDX = ttd_pkg::SLOT_W'(ttd_pkg::SLOT_COUNT - 1);

  ttd_pkg::state_e                 state_q, state_d;
  logic [ttd_pkg::RES_W-1:0]       res_q;
  logic [ttd_pkg::TICK_W-1:0]      tick_q, tick_d;
  logic [ttd_pkg::UCNT_W-1:0]      used_q, used_d;
  logic [ttd_pkg::SLOT_W-1:0]      idx_q, idx_d;
  logic [ttd_pkg::NCNT_W-1:0]      n_q, n_d;
  logic                            pend_valid_q, pend_valid_d;
  logic [ttd_pkg::SLOT_W-1:0]      pend_slot_q, pend_slot_d;
  logic [ttd_pkg::HANDLE_W-1:0]    pend_handle_q, pend_handle_d;
  logic                            out_valid_q;
  ttd_pkg::result_t                out_q;
  logic [2:0]                      req_slot_q;
  logic [ttd_pkg::PERIOD_W-1:0]    req_period_q;
  logic [1:0]                      req_mode_q;
  logic [ttd_pkg::HANDLE_W-1:0]    req_handle_q;

  logic                            out_free;
  logic                            idx_last;
  logic                            hit;
  logic                            report;
  logic                            hit_stall;
  logic                            stop_end;
  logic [ttd_pkg::SLOT_W-1:0]      cre_idx;
  logic [ttd_pkg::PERIOD_W-1:0]    period_eff;
  ttd_pkg::status_e                cre_status;
  logic                            emit;
  ttd_pkg::result_t                emit_res;

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    idx_last   = (idx_q == LAST_IDX);
    hit        = tbl_rd_i.busy && alu_eq_i;
    report     = (n_q < ttd_pkg::NCNT_W'(ttd_pkg::MAX_RESULTS));
    hit_stall  = report && pend_valid_q && !out_free;
    stop_end   = (req_handle_q == '0) || hit || idx_last;
    cre_idx    = ttd_pkg::SLOT_W'(req_slot_q);
    period_eff = (req_period_q == '0) ? ttd_pkg::PERIOD_W'(1) : req_period_q;
    if (res_q == '0 || res_q < ttd_pkg::RES_W'(ttd_pkg::MIN_RESOLUTION)) begin
      cre_status = ttd_pkg::STAT_NOT_INIT;
    end else if (used_q >= ttd_pkg::UCNT_W'(ttd_pkg::SLOT_COUNT)) begin
      cre_status = ttd_pkg::STAT_FULL;
    end else if (!(6'(req_slot_q) < 6'(ttd_pkg::SLOT_COUNT)) || tbl_rd_i.busy) begin
      cre_status = ttd_pkg::STAT_TAKEN;
    end else if (req_mode_q != ttd_pkg::MODE_ONESHOT && req_mode_q != ttd_pkg::MODE_PERIODIC) begin
      cre_status = ttd_pkg::STAT_BAD_MODE;
    end else begin
      cre_status = ttd_pkg::STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_action_i)
            ttd_pkg::ACT_CREATE: state_d = ttd_pkg::ST_CREATE;
            ttd_pkg::ACT_STOP:   state_d = ttd_pkg::ST_STOP;
            ttd_pkg::ACT_TICK:   state_d = ttd_pkg::ST_TICK_INC;
            default:             state_d = ttd_pkg::ST_IDLE;
          endcase
        end
      end
      ttd_pkg::ST_CREATE: begin
        if (out_free) state_d = ttd_pkg::ST_IDLE;
      end
      ttd_pkg::ST_STOP: begin
        if (stop_end && out_free) state_d = ttd_pkg::ST_IDLE;
      end
      ttd_pkg::ST_TICK_INC: state_d = ttd_pkg::ST_TICK_SCAN;
      ttd_pkg::ST_TICK_SCAN: begin
        if (hit) state_d = ttd_pkg::ST_TICK_HIT;
        else if (idx_last) state_d = ttd_pkg::ST_TICK_DONE;
      end
      ttd_pkg::ST_TICK_HIT: begin
        if (!hit_stall) state_d = idx_last ? ttd_pkg::ST_TICK_DONE : ttd_pkg::ST_TICK_SCAN;
      end
      ttd_pkg::ST_TICK_DONE: begin
        if (out_free) state_d = ttd_pkg::ST_IDLE;
      end
      default: state_d = ttd_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o    = (state_q == ttd_pkg::ST_IDLE);
    tbl_rd_idx_o  = (state_q == ttd_pkg::ST_CREATE) ? cre_idx : idx_q;
    alu_a_o       = '0;
    alu_b_o       = '0;
    tbl_wr_o      = '0;
    tbl_wr_o.op   = ttd_pkg::TW_NONE;
    emit          = 1'b0;
    emit_res      = '0;
    emit_res.kind = ttd_pkg::KIND_STATUS;
    emit_res.status = ttd_pkg::STAT_OK;
    tick_d        = tick_q;
    used_d        = used_q;
    idx_d         = idx_q;
    n_d           = n_q;
    pend_valid_d  = pend_valid_q;
    pend_slot_d   = pend_slot_q;
    pend_handle_d = pend_handle_q;
    unique case (state_q)
      ttd_pkg::ST_IDLE: begin
        idx_d = '0;
      end
      ttd_pkg::ST_CREATE: begin
        alu_a_o = tick_q;
        alu_b_o = ttd_pkg::TICK_W'(period_eff);
        if (out_free) begin
          emit            = 1'b1;
          emit_res.status = cre_status;
          emit_res.last   = 1'b1;
          if (cre_status == ttd_pkg::STAT_OK) begin
            tbl_wr_o.op       = ttd_pkg::TW_CREATE;
            tbl_wr_o.idx      = cre_idx;
            tbl_wr_o.deadline = alu_sum_i;
            tbl_wr_o.period   = period_eff;
            tbl_wr_o.handle   = req_handle_q;
            tbl_wr_o.periodic = (req_mode_q == ttd_pkg::MODE_PERIODIC);
            used_d            = used_q + 1'b1;
          end
        end
      end
      ttd_pkg::ST_STOP: begin
        alu_a_o = ttd_pkg::TICK_W'(req_handle_q);
        alu_b_o = ttd_pkg::TICK_W'(tbl_rd_i.handle);
        if (stop_end) begin
          if (out_free) begin
            emit          = 1'b1;
            emit_res.last = 1'b1;
            if (req_handle_q == '0) begin
              emit_res.status = ttd_pkg::STAT_NULL;
            end else if (hit) begin
              if (tbl_rd_i.periodic) begin
                emit_res.status = ttd_pkg::STAT_OK;
                tbl_wr_o.op     = ttd_pkg::TW_FREE;
                tbl_wr_o.idx    = idx_q;
                if (used_q != '0) used_d = used_q - 1'b1;
              end else begin
                emit_res.status = ttd_pkg::STAT_ONE_SHOT;
              end
            end else begin
              emit_res.status = ttd_pkg::STAT_NOT_FOUND;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ttd_pkg::ST_TICK_INC: begin
        alu_a_o      = tick_q;
        alu_b_o      = ttd_pkg::TICK_W'(1);
        tick_d       = alu_sum_i;
        idx_d        = '0;
        n_d          = '0;
        pend_valid_d = 1'b0;
      end
      ttd_pkg::ST_TICK_SCAN: begin
        alu_a_o = tbl_rd_i.deadline;
        alu_b_o = tick_q;
        if (!hit && !idx_last) idx_d = idx_q + 1'b1;
      end
      ttd_pkg::ST_TICK_HIT: begin
        alu_a_o = tbl_rd_i.deadline;
        alu_b_o = ttd_pkg::TICK_W'(tbl_rd_i.period);
        if (!hit_stall) begin
          if (report) begin
            if (pend_valid_q) begin
              emit                  = 1'b1;
              emit_res.kind         = ttd_pkg::KIND_DISPATCH;
              emit_res.fired_slot   = 3'(pend_slot_q);
              emit_res.fired_handle = pend_handle_q;
            end
            pend_valid_d  = 1'b1;
            pend_slot_d   = idx_q;
            pend_handle_d = tbl_rd_i.handle;
            n_d           = n_q + 1'b1;
          end
          tbl_wr_o.idx = idx_q;
          if (tbl_rd_i.periodic) begin
            tbl_wr_o.op       = ttd_pkg::TW_RELOAD;
            tbl_wr_o.deadline = alu_sum_i;
          end else begin
            tbl_wr_o.op = ttd_pkg::TW_FREE;
            if (used_q != '0) used_d = used_q - 1'b1;
          end
          if (!idx_last) idx_d = idx_q + 1'b1;
        end
      end
      ttd_pkg::ST_TICK_DONE: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.last = 1'b1;
          if (pend_valid_q) begin
            emit_res.kind         = ttd_pkg::KIND_DISPATCH;
            emit_res.fired_slot   = 3'(pend_slot_q);
            emit_res.fired_handle = pend_handle_q;
          end else begin
            emit_res.kind = ttd_pkg::KIND_IDLE;
          end
          pend_valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ttd_pkg::ST_IDLE;
      res_q        <= '0;
      tick_q       <= '0;
      used_q       <= '0;
      idx_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_q       <= tick_d;
      used_q       <= used_d;
      idx_q        <= idx_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) res_q <= cfg_wdata_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q   <= pend_slot_d;
    pend_handle_q <= pend_handle_d;
    if (emit) out_q <= emit_res;
    if (in_valid_i && in_ready_o) begin
      req_slot_q   <= in_slot_i;
      req_period_q <= in_period_i;
      req_mode_q   <= in_mode_i;
      req_handle_q <= in_handle_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign used_o      = used_q;

endmodule

/* src/tick_task_dispatch_table_core.sv */
// top level of the tick task dispatch table
//
//  channel   direction  handshake                 contents
//  s_axis    in         tvalid / tready           request: tuser action, tdata fields
//  m_axis    out        tvalid / tready / tlast   result: tuser kind, tdata fields
//  cfg       in         cfg_we_i                  tick_resolution write
//
//  create checks the requested slot; stop scans the slots in order (one slot compared per cycle)
//  a tick advances the counter, then scans every slot and reloads or frees each due slot, all through the one adder
//  s_axis_tready is high only while the sequencer is idle
//  a held m_axis result stalls the sequencer at its next result
//  reset clears the tick counter, the busy flags and the used count
module tick_task_dispatch_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // slot[2:0] period[18:3] mode[20:19] task_handle[28:21]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[2:0] fired_slot[5:3] fired_handle[13:6]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  `include "tick_task_dispatch_table_core_macros.svh"

  ttd_pkg::result_t                    out_res;
  ttd_pkg::tbl_wr_t                    tbl_wr;
  ttd_pkg::tbl_rd_t                    tbl_rd;
  logic [ttd_pkg::SLOT_W-1:0]          tbl_rd_idx;
  logic [ttd_pkg::SLOT_COUNT-1:0]      busy;
  logic [ttd_pkg::TICK_W-1:0]          alu_a;
  logic [ttd_pkg::TICK_W-1:0]          alu_b;
  logic [ttd_pkg::TICK_W-1:0]          alu_sum;
  logic                                alu_eq;
  logic [ttd_pkg::UCNT_W-1:0]          used;

  ttd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (ttd_pkg::action_e'(s_axis_tuser)),
    .in_slot_i    (s_axis_tdata[2:0]),
    .in_period_i  (s_axis_tdata[18:3]),
    .in_mode_i    (s_axis_tdata[20:19]),
    .in_handle_i  (s_axis_tdata[28:21]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (out_res),
    .tbl_rd_idx_o (tbl_rd_idx),
    .tbl_rd_i     (tbl_rd),
    .tbl_wr_o     (tbl_wr),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_sum_i    (alu_sum),
    .alu_eq_i     (alu_eq),
    .used_o       (used)
  );

  ttd_slot_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_idx_i (tbl_rd_idx),
    .rd_o     (tbl_rd),
    .busy_o   (busy)
  );

  ttd_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .eq_o  (alu_eq)
  );

  assign m_axis_tdata = {2'b00, out_res.fired_handle, out_res.fired_slot, 3'(out_res.status)};
  assign m_axis_tuser = 2'(out_res.kind);
  assign m_axis_tlast = out_res.last;

  `TTD_ASSERT_HOLDS(a_used_matches_busy, clk_i, rst_ni, int'(used) == $countones(busy))
  `TTD_ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && ttd_pkg::action_e'(s_axis_tuser) != ttd_pkg::ACT_NONE, !s_axis_tready)
  `TTD_ASSERT_SAME(a_idle_tick_is_last, clk_i, rst_ni, m_axis_tvalid && out_res.kind == ttd_pkg::KIND_IDLE, m_axis_tlast)

endmodule
